// ===== design/bep_pkg.sv =====
`timescale 1ns / 1ps
package bep_pkg;

	// byte classes seen by the parser
	typedef enum logic [2:0] {
		CL_DIGIT,
		CL_E,
		CL_I,
		CL_L,
		CL_D,
		CL_COLON,
		CL_MINUS,
		CL_OTHER
	} cls_t;

	// one classified beat in the front-to-back queue
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		cls_t       cls;
		logic [3:0] dval;
	} beat_t;

	typedef enum logic [3:0] {
		M_IDLE,
		M_VALUE,
		M_KEY,
		M_INT_START,
		M_INT_SIGN,
		M_INT_DIGITS,
		M_STR_LEN,
		M_STR_BODY,
		M_DONE,
		M_ERROR
	} mode_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_STR_FIRST,
		ACT_DICT_END,
		ACT_LIST_END,
		ACT_BAD,
		ACT_DEEP,
		ACT_INT_OPEN,
		ACT_PUSH,
		ACT_NEG,
		ACT_INT_FIRST,
		ACT_INT_DIGIT,
		ACT_INT_END,
		ACT_LEN_DIGIT,
		ACT_STR_COLON,
		ACT_STR_BYTE
	} act_t;

	typedef enum logic [2:0] {
		EV_INT,
		EV_STR_START,
		EV_STR_BYTE,
		EV_LIST_START,
		EV_LIST_END,
		EV_DICT_START,
		EV_DICT_END,
		EV_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_INVALID,
		ERR_DEPTH,
		ERR_TRUNC
	} err_t;

	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

// ===== design/bencode_event_parser.sv =====
`timescale 1ns / 1ps
// Streaming bencode parser: one buffer byte per beat in, at most one event per byte out.
// A byte is classified and queued in a two-entry queue, then the parser consumes one
// queued byte per cycle, so a sustained rate of one byte per cycle holds while the
// event output is not stalled; a byte passes a queue entry, then the output register.
// first_flag restarts the parse, and errors or a finished top-level value mute the
// stream until the next first_flag. Nesting depth is MAX_DEPTH, string lengths up to
// LENGTH_BITS bits. No clearing pass follows reset.
module bencode_event_parser #(
	parameter int MAX_DEPTH   = 16,
	parameter int LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  in_byte,
	input  logic        first_flag,
	input  logic        last_flag,
	output logic        event_valid,
	input  logic        event_stall,
	output logic [2:0]  event_kind,
	output logic signed [63:0] int_value,
	output logic [23:0] str_length,
	output logic [7:0]  payload_byte,
	output logic        is_key,
	output logic        end_of_string,
	output logic        top_done,
	output logic [1:0]  error_code
);
	import bep_pkg::*;

	logic  head_valid;
	beat_t head;
	logic  pop;

	bep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.in_byte    (in_byte),
		.first_flag (first_flag),
		.last_flag  (last_flag),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	bep_back #(
		.MAX_DEPTH   (MAX_DEPTH),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.event_valid   (event_valid),
		.event_stall   (event_stall),
		.event_kind    (event_kind),
		.int_value     (int_value),
		.str_length    (str_length),
		.payload_byte  (payload_byte),
		.is_key        (is_key),
		.end_of_string (end_of_string),
		.top_done      (top_done),
		.error_code    (error_code)
	);
endmodule

// ===== design/bep_front.sv =====
`timescale 1ns / 1ps
module bep_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_stall,
	input  logic [7:0]    in_byte,
	input  logic          first_flag,
	input  logic          last_flag,
	output logic          head_valid,
	output bep_pkg::beat_t head,
	input  logic          pop
);
	import bep_pkg::*;

	beat_t      ent_q [2];
	logic [1:0] count_q;
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	beat_t      beat;
	logic       push;
	logic [7:0] dsub;

	// classify the incoming byte
	always_comb begin
		dsub       = in_byte - CH_ZERO;
		beat.data  = in_byte;
		beat.first = first_flag;
		beat.last  = last_flag;
		beat.dval  = 4'd0;
		case (in_byte)
			CH_E:     beat.cls = CL_E;
			CH_I:     beat.cls = CL_I;
			CH_L:     beat.cls = CL_L;
			CH_D:     beat.cls = CL_D;
			CH_COLON: beat.cls = CL_COLON;
			CH_MINUS: beat.cls = CL_MINUS;
			default:  beat.cls = CL_OTHER;
		endcase
		if (in_byte inside {[CH_ZERO:CH_NINE]}) begin
			beat.cls  = CL_DIGIT;
			beat.dval = dsub[3:0];
		end
	end

	assign byte_stall = (count_q == 2'd2);
	assign push       = byte_valid && !byte_stall;
	assign head_valid = (count_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	// two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= beat;
	end
endmodule

// ===== design/bep_back.sv =====
`timescale 1ns / 1ps
module bep_back #(
	parameter int MAX_DEPTH   = 16,
	parameter int LENGTH_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  bep_pkg::beat_t head,
	output logic          pop,
	output logic          event_valid,
	input  logic          event_stall,
	output logic [2:0]    event_kind,
	output logic signed [63:0] int_value,
	output logic [23:0]   str_length,
	output logic [7:0]    payload_byte,
	output logic          is_key,
	output logic          end_of_string,
	output logic          top_done,
	output logic [1:0]    error_code
);
	import bep_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int LB = LENGTH_BITS;

	// parser state
	mode_t             mode_q;
	logic [DW-1:0]     depth_q;
	logic              top_q;
	logic [MAX_DEPTH-1:0] stack_q;
	logic [63:0]       acc_q;
	logic              neg_q;
	logic              lz_q;
	logic [LB-1:0]     rem_q;
	logic              key_q;

	mode_t             mode_eff, mode_pre, mode_d, fin_mode;
	logic [DW-1:0]     depth_eff, depth_d, f_depth;
	logic              top_d, f_top, fin_done, str_key, stack_rd;
	logic [DW:0]       rd_wide;
	act_t              act;
	logic [67:0]       int_next;
	logic [63:0]       int_limit;
	logic [LB+3:0]     len_next;
	logic [LB-1:0]     rem_dec;
	logic              trunc;
	logic              fire;
	logic [LB+23:0]    len_ext;

	// output stage
	logic              ev_valid_q;
	logic [2:0]        ev_kind, kind_q;
	logic [63:0]       ev_int, int_q;
	logic [23:0]       ev_len, len_q;
	logic [7:0]        ev_byte, byte_q;
	logic              ev_key, key_out_q, ev_eos, eos_q, ev_done, done_q;
	logic [1:0]        ev_err, err_q;

	assign pop       = head_valid && (!ev_valid_q || !event_stall);
	assign mode_eff  = head.first ? M_VALUE : mode_q;
	assign depth_eff = head.first ? '0 : depth_q;
	assign rd_wide   = {1'b0, depth_eff} - (DW + 1)'(2);
	assign stack_rd  = stack_q[rd_wide[IW-1:0]];
	assign int_next  = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, head.dval};
	assign int_limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
	assign len_next  = {rem_q, 3'b000} + {3'b000, rem_q, 1'b0} + {{LB{1'b0}}, head.dval};
	assign rem_dec   = rem_q - LB'(1);

	// decode what this byte does
	always_comb begin
		act = ACT_NONE;
		case (mode_eff)
			M_VALUE, M_KEY: begin
				if (head.cls == CL_DIGIT) act = ACT_STR_FIRST;
				else if (head.cls == CL_E && mode_eff == M_KEY && depth_eff != '0)
					act = ACT_DICT_END;
				else if (head.cls == CL_E && mode_eff == M_VALUE && depth_eff != '0 && !top_q)
					act = ACT_LIST_END;
				else if (mode_eff == M_KEY) act = ACT_BAD;
				else if (head.cls == CL_I) act = ACT_INT_OPEN;
				else if (head.cls == CL_L || head.cls == CL_D)
					act = (depth_eff == DW'(MAX_DEPTH)) ? ACT_DEEP : ACT_PUSH;
				else act = ACT_BAD;
			end
			M_INT_START, M_INT_SIGN: begin
				if (head.cls == CL_MINUS && mode_eff == M_INT_START) act = ACT_NEG;
				else if (head.cls == CL_DIGIT) act = ACT_INT_FIRST;
				else act = ACT_BAD;
			end
			M_INT_DIGITS: begin
				if (head.cls == CL_DIGIT)
					act = (lz_q || int_next > {4'd0, int_limit}) ? ACT_BAD : ACT_INT_DIGIT;
				else if (head.cls == CL_E) act = ACT_INT_END;
				else act = ACT_BAD;
			end
			M_STR_LEN: begin
				if (head.cls == CL_DIGIT)
					act = (len_next[LB+3:LB] != 4'd0) ? ACT_BAD : ACT_LEN_DIGIT;
				else if (head.cls == CL_COLON) act = ACT_STR_COLON;
				else act = ACT_BAD;
			end
			M_STR_BODY: act = ACT_STR_BYTE;
			default: act = ACT_NONE;
		endcase
	end

	// where a finished value leaves the parse
	always_comb begin
		f_depth  = (act == ACT_DICT_END || act == ACT_LIST_END) ? depth_eff - DW'(1) : depth_eff;
		f_top    = (act == ACT_DICT_END || act == ACT_LIST_END) ? stack_rd : top_q;
		str_key  = (act == ACT_STR_COLON || act == ACT_STR_BYTE) && key_q;
		fin_done = !str_key && (f_depth == '0);
		if (str_key) fin_mode = M_VALUE;
		else if (f_depth == '0) fin_mode = M_DONE;
		else fin_mode = f_top ? M_KEY : M_VALUE;
	end

	// next mode
	always_comb begin
		case (act)
			ACT_STR_FIRST, ACT_LEN_DIGIT: mode_pre = M_STR_LEN;
			ACT_DICT_END, ACT_LIST_END, ACT_INT_END: mode_pre = fin_mode;
			ACT_BAD, ACT_DEEP: mode_pre = M_ERROR;
			ACT_INT_OPEN: mode_pre = M_INT_START;
			ACT_PUSH: mode_pre = (head.cls == CL_D) ? M_KEY : M_VALUE;
			ACT_NEG: mode_pre = M_INT_SIGN;
			ACT_INT_FIRST, ACT_INT_DIGIT: mode_pre = M_INT_DIGITS;
			ACT_STR_COLON: mode_pre = (rem_q == '0) ? fin_mode : M_STR_BODY;
			ACT_STR_BYTE: mode_pre = (rem_dec == '0) ? fin_mode : M_STR_BODY;
			default: mode_pre = mode_eff;
		endcase
		trunc  = head.last && mode_pre != M_DONE && mode_pre != M_ERROR && mode_pre != M_IDLE;
		mode_d = trunc ? M_ERROR : mode_pre;
		depth_d = depth_eff;
		top_d   = top_q;
		if (act == ACT_PUSH) begin
			depth_d = depth_eff + DW'(1);
			top_d   = (head.cls == CL_D);
		end else if (act == ACT_DICT_END || act == ACT_LIST_END) begin
			depth_d = f_depth;
			top_d   = stack_rd;
		end
	end

	// event fields
	always_comb begin
		len_ext = {24'd0, rem_q};
		fire    = 1'b0;
		ev_kind = EV_INT;
		ev_int  = '0;
		ev_len  = '0;
		ev_byte = '0;
		ev_key  = 1'b0;
		ev_eos  = 1'b0;
		ev_done = 1'b0;
		ev_err  = ERR_NONE;
		case (act)
			ACT_DICT_END: begin
				fire = 1'b1; ev_kind = EV_DICT_END; ev_done = fin_done;
			end
			ACT_LIST_END: begin
				fire = 1'b1; ev_kind = EV_LIST_END; ev_done = fin_done;
			end
			ACT_PUSH: begin
				fire    = 1'b1;
				ev_kind = (head.cls == CL_D) ? EV_DICT_START : EV_LIST_START;
			end
			ACT_INT_END: begin
				fire    = 1'b1;
				ev_kind = EV_INT;
				ev_int  = neg_q ? (64'd0 - acc_q) : acc_q;
				ev_done = fin_done;
			end
			ACT_STR_COLON: begin
				fire    = 1'b1;
				ev_kind = EV_STR_START;
				ev_len  = len_ext[23:0];
				ev_key  = key_q;
				ev_eos  = (rem_q == '0);
				ev_done = (rem_q == '0) && fin_done;
			end
			ACT_STR_BYTE: begin
				fire    = 1'b1;
				ev_kind = EV_STR_BYTE;
				ev_byte = head.data;
				ev_key  = key_q;
				ev_eos  = (rem_dec == '0);
				ev_done = (rem_dec == '0) && fin_done;
			end
			ACT_BAD: begin
				fire = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_INVALID;
			end
			ACT_DEEP: begin
				fire = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_DEPTH;
			end
			default: fire = 1'b0;
		endcase
		if (trunc) begin
			fire    = 1'b1;
			ev_kind = EV_ERROR;
			ev_int  = '0;
			ev_len  = '0;
			ev_byte = '0;
			ev_key  = 1'b0;
			ev_eos  = 1'b0;
			ev_done = 1'b0;
			ev_err  = ERR_TRUNC;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			depth_q    <= '0;
			top_q      <= 1'b0;
			ev_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q  <= mode_d;
				depth_q <= depth_d;
				top_q   <= top_d;
			end
			if (pop) ev_valid_q <= fire;
			else if (!event_stall) ev_valid_q <= 1'b0;
		end
	end

	// value registers and container stack
	always_ff @(posedge clk) begin
		if (pop) begin
			if (act == ACT_PUSH) stack_q[depth_eff[IW-1:0]] <= (head.cls == CL_D);
			case (act)
				ACT_INT_OPEN: begin
					acc_q <= '0; neg_q <= 1'b0; lz_q <= 1'b0;
				end
				ACT_NEG: neg_q <= 1'b1;
				ACT_INT_FIRST: begin
					acc_q <= {60'd0, head.dval};
					lz_q  <= (head.dval == 4'd0);
				end
				ACT_INT_DIGIT: acc_q <= int_next[63:0];
				ACT_STR_FIRST: begin
					rem_q <= LB'(head.dval);
					key_q <= (mode_eff == M_KEY);
				end
				ACT_LEN_DIGIT: rem_q <= len_next[LB-1:0];
				ACT_STR_BYTE: rem_q <= rem_dec;
				default: ;
			endcase
			kind_q    <= ev_kind;
			int_q     <= ev_int;
			len_q     <= ev_len;
			byte_q    <= ev_byte;
			key_out_q <= ev_key;
			eos_q     <= ev_eos;
			done_q    <= ev_done;
			err_q     <= ev_err;
		end
	end

	assign event_valid   = ev_valid_q;
	assign event_kind    = kind_q;
	assign int_value     = int_q;
	assign str_length    = len_q;
	assign payload_byte  = byte_q;
	assign is_key        = key_out_q;
	assign end_of_string = eos_q;
	assign top_done      = done_q;
	assign error_code    = err_q;
endmodule

// ===== design/bep_checker.sv =====
`timescale 1ns / 1ps
module bep_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_stall,
	input logic [7:0]  in_byte,
	input logic        first_flag,
	input logic        last_flag,
	input logic        event_valid,
	input logic        event_stall,
	input logic [2:0]  event_kind,
	input logic signed [63:0] int_value,
	input logic [23:0] str_length,
	input logic [7:0]  payload_byte,
	input logic        is_key,
	input logic        end_of_string,
	input logic        top_done,
	input logic [1:0]  error_code
);
	import bep_pkg::*;

	// a stalled event holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_stall |=> event_valid && $stable(event_kind) && $stable(int_value))
		else $error("stalled event changed");

	// error code appears exactly on error events
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> ((event_kind == EV_ERROR) == (error_code != ERR_NONE)))
		else $error("error code mismatch");

	// key and end-of-string marks only on string events
	a_str: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && (is_key || end_of_string) |->
			(event_kind == EV_STR_START || event_kind == EV_STR_BYTE))
		else $error("string flag on non-string event");

	// a top-level completion never comes from a container start or an error
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && top_done |->
			(event_kind != EV_ERROR && event_kind != EV_LIST_START &&
			 event_kind != EV_DICT_START))
		else $error("top done on wrong event");
endmodule

bind bencode_event_parser bep_checker u_bep_checker (.*);
